>>> hdl/bmdpc_pkg.sv
// Shared types and constants of the meter disk pulse counter.
// No dependencies; imported by the top level, the checker and the testbench (not by bmdpc_div).
package bmdpc_pkg;

	typedef enum logic [1:0] {
		ROT_UNKNOWN = 2'd0,
		ROT_LEFT    = 2'd1,
		ROT_RIGHT   = 2'd2
	} rotation_t;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PPK      = 2'd1;

	localparam logic [15:0] DEBOUNCE_RST = 16'd50;
	localparam logic [15:0] PPK_RST      = 16'd375;

	localparam int unsigned THR_W  = 26;
	localparam int unsigned PROD_W = 48;
	localparam logic [9:0]  US_PER_MS = 10'd1000;
	localparam logic [31:0] POWER_DIVIDEND = 32'd3600000000;
	localparam logic [31:0] POWER_MAX = 32'h7FFF_FFFF;

endpackage

>>> hdl/bmdpc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Standalone; used by the top level for the power quotient.
module bmdpc_div #(
	parameter int unsigned W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int unsigned CW = $clog2(W + 1);

	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic          fits;

	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign fits    = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			div_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= dividend;
				div_q  <= divisor;
				cnt_q  <= CW'(W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= fits ? (shifted - {1'b0, div_q}) : shifted;
				quo_q  <= {quo_q[W-2:0], fits};
				cnt_q  <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> hdl/bidirectional_meter_disk_pulse_counter.sv
// Path: a rejected edge or an edge that counts no pulse goes from S_EVAL to S_OUT;
// a counted pulse passes S_MUL, then where needed S_CHK and the 32-step divider in S_DIV,
// and S_APPLY. One edge at a time: edge_stall stays high until the result is taken.
// Reset (arst_n low, asynchronous): edge times, rotation and totals clear to zero,
// debounce_ms to 50 and pulses_per_kwh to 375.
module bidirectional_meter_disk_pulse_counter
	import bmdpc_pkg::*;
#(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 edge_valid,
	output logic                 edge_stall,
	input  logic                 sensor,
	input  logic [31:0]          time_us,
	input  logic [31:0]          time_ms,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic                 pulse_counted,
	output logic                 double_pulse,
	output logic [1:0]           direction,
	output logic signed [31:0]   power_w,
	output logic signed [31:0]   total_w,
	output logic [31:0]          used_w,
	output logic [31:0]          returned_w
);

	localparam int unsigned XW   = (TIME_BITS > 32) ? TIME_BITS : 32;
	localparam int unsigned DXW  = XW + 1;
	localparam int unsigned CMPW = (TIME_BITS > THR_W) ? TIME_BITS : THR_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_MUL,
		S_CHK,
		S_DIV,
		S_APPLY,
		S_OUT
	} state_t;

	state_t               state_q;
	logic [15:0]          debounce_q;
	logic [15:0]          ppk_q;
	logic [THR_W-1:0]     thr_q;
	logic                 sensor_q;
	logic [TIME_BITS-1:0] t_us_q;
	logic [TIME_BITS-1:0] t_ms_q;
	logic [TIME_BITS-1:0] left_q;
	logic [TIME_BITS-1:0] right_q;
	logic [TIME_BITS-1:0] full_q;
	logic [TIME_BITS-1:0] last_ms_q;
	logic [TIME_BITS-1:0] dur_q;
	rotation_t            rotation_q;
	logic [PROD_W-1:0]    prod_q;
	logic                 dur_big_q;
	logic [31:0]          pwr_q;
	logic [31:0]          power_q;
	logic [31:0]          total_q;
	logic [31:0]          used_q;
	logic [31:0]          returned_q;
	logic                 counted_q;
	logic                 dbl_q;

	logic [XW-1:0]        us_x;
	logic [XW-1:0]        ms_x;
	logic [TIME_BITS-1:0] mine;
	logic [TIME_BITS-1:0] other;
	rotation_t            my_dir;
	logic [TIME_BITS-1:0] diff;
	logic                 edge_ok;
	logic [DXW-1:0]       dur_x;
	logic                 too_big;
	logic                 div_start;
	logic                 div_done;
	logic [31:0]          div_quo;
	logic [31:0]          neg_pwr;

	assign us_x = XW'(time_us);
	assign ms_x = XW'(time_ms);

	assign mine    = sensor_q ? right_q : left_q;
	assign other   = sensor_q ? left_q : right_q;
	assign my_dir  = sensor_q ? ROT_RIGHT : ROT_LEFT;
	assign diff    = t_us_q - mine;
	// signed wrap-safe difference: negative spacing never passes
	assign edge_ok = !diff[TIME_BITS-1] && (CMPW'(diff) >= CMPW'(thr_q));

	assign dur_x     = DXW'(dur_q);
	// product beyond the dividend gives a zero quotient
	assign too_big   = dur_big_q || (prod_q > PROD_W'(POWER_DIVIDEND));
	assign div_start = (state_q == S_CHK) && !too_big;
	assign neg_pwr   = 32'd0 - pwr_q;

	bmdpc_div #(
		.W(32)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (POWER_DIVIDEND),
		.divisor  (prod_q[31:0]),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			debounce_q <= DEBOUNCE_RST;
			ppk_q      <= PPK_RST;
			thr_q      <= '0;
			sensor_q   <= 1'b0;
			t_us_q     <= '0;
			t_ms_q     <= '0;
			left_q     <= '0;
			right_q    <= '0;
			full_q     <= '0;
			last_ms_q  <= '0;
			dur_q      <= '0;
			rotation_q <= ROT_UNKNOWN;
			prod_q     <= '0;
			dur_big_q  <= 1'b0;
			pwr_q      <= '0;
			power_q    <= '0;
			total_q    <= '0;
			used_q     <= '0;
			returned_q <= '0;
			counted_q  <= 1'b0;
			dbl_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_DEBOUNCE) begin
					debounce_q <= cfg_data;
				end else if (cfg_index == REG_PPK) begin
					ppk_q <= cfg_data;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (edge_valid) begin
						sensor_q  <= sensor;
						t_us_q    <= us_x[TIME_BITS-1:0];
						t_ms_q    <= ms_x[TIME_BITS-1:0];
						thr_q     <= THR_W'(debounce_q) * THR_W'(US_PER_MS);
						counted_q <= 1'b0;
						dbl_q     <= 1'b0;
						state_q   <= S_EVAL;
					end
				end
				S_EVAL: begin
					dur_q   <= t_ms_q - last_ms_q;
					state_q <= S_OUT;
					if (edge_ok) begin
						if (rotation_q == my_dir) begin
							if (other > full_q) begin
								full_q    <= mine;
								counted_q <= 1'b1;
								last_ms_q <= t_ms_q;
								state_q   <= S_MUL;
							end else begin
								dbl_q <= 1'b1;
							end
						end else if (full_q == other) begin
							rotation_q <= my_dir;
						end
						if (sensor_q) begin
							right_q <= t_us_q;
						end else begin
							left_q <= t_us_q;
						end
					end
				end
				S_MUL: begin
					if ((dur_q == '0) || (ppk_q == '0)) begin
						pwr_q   <= POWER_MAX;
						state_q <= S_APPLY;
					end else begin
						prod_q    <= PROD_W'(ppk_q) * PROD_W'(dur_x[31:0]);
						dur_big_q <= |dur_x[DXW-1:32];
						state_q   <= S_CHK;
					end
				end
				S_CHK: begin
					if (too_big) begin
						pwr_q   <= '0;
						state_q <= S_APPLY;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						pwr_q   <= (div_quo > POWER_MAX) ? POWER_MAX : div_quo;
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (rotation_q == ROT_LEFT) begin
						returned_q <= returned_q + pwr_q;
						power_q    <= neg_pwr;
						total_q    <= total_q + neg_pwr;
					end else begin
						used_q  <= used_q + pwr_q;
						power_q <= pwr_q;
						total_q <= total_q + pwr_q;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!res_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cfg_ready     = 1'b1;
	assign edge_stall    = (state_q != S_IDLE);
	assign res_valid     = (state_q == S_OUT);
	assign pulse_counted = counted_q;
	assign double_pulse  = dbl_q;
	assign direction     = rotation_q;
	assign power_w       = power_q;
	assign total_w       = total_q;
	assign used_w        = used_q;
	assign returned_w    = returned_q;

endmodule

>>> hdl/bmdpc_chk.sv
// Port-level checks for the meter disk pulse counter, bound to its top level.
// Depends on bmdpc_pkg for the rotation codes.
module bmdpc_chk
	import bmdpc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        edge_valid,
	input logic        edge_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic        pulse_counted,
	input logic        double_pulse,
	input logic [1:0]  direction,
	input logic [31:0] power_w
);

	// an accepted request blocks the input and has no result on the next edge
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		edge_valid && !edge_stall |=> edge_stall && !res_valid)
		else $error("edge accepted while result path not clear");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> edge_stall)
		else $error("input open while a result is pending");

	a_counted_sane: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && pulse_counted |-> !double_pulse && (direction != ROT_UNKNOWN))
		else $error("counted pulse with double flag or unknown direction");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(power_w))
		else $error("stalled result dropped or changed");

endmodule

bind bidirectional_meter_disk_pulse_counter bmdpc_chk u_bmdpc_chk (.*);

>>> verif/tb_bidirectional_meter_disk_pulse_counter.sv
// Testbench for the meter disk pulse counter: sends sensor edges through the request
// handshake, predicts every reading in-bench and checks each one field by field.
// Depends on bmdpc_pkg and bidirectional_meter_disk_pulse_counter.
`timescale 1ns / 100ps

module tb_bidirectional_meter_disk_pulse_counter;
	import bmdpc_pkg::*;

	typedef struct {
		logic        pulse_counted;
		logic        double_pulse;
		rotation_t   direction;
		logic [31:0] power_w;
		logic [31:0] total_w;
		logic [31:0] used_w;
		logic [31:0] returned_w;
	} meter_reading_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;
	logic                 edge_valid;
	logic                 edge_stall;
	logic                 sensor;
	logic [31:0]          time_us;
	logic [31:0]          time_ms;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic                 pulse_counted;
	logic                 double_pulse;
	logic [1:0]           direction;
	logic signed [31:0]   power_w;
	logic signed [31:0]   total_w;
	logic [31:0]          used_w;
	logic [31:0]          returned_w;

	// predictor copy of the block
	logic [15:0] set_debounce_ms = DEBOUNCE_RST;
	logic [15:0] set_ppk = PPK_RST;
	logic [31:0] mark_us [2] = '{32'd0, 32'd0};
	logic [31:0] pulse_mark_us = '0;
	rotation_t   disk_rot = ROT_UNKNOWN;
	logic [31:0] last_count_ms = '0;
	logic [31:0] watts_now = '0;
	logic [31:0] sum_net = '0;
	logic [31:0] sum_used = '0;
	logic [31:0] sum_returned = '0;

	meter_reading_t pending_readings [$];

	// stimulus time base
	logic [31:0] now_us = '0;
	logic [31:0] now_ms = '0;
	bit          last_sensor;
	bit          idle_on = 1'b1;

	int mismatches = 0;
	int readings_checked = 0;
	int items_sent = 0;
	int debounced_seen = 0;
	int pulses_seen = 0;
	int returning_seen = 0;
	int doubles_seen = 0;
	int settings_seen = 0;

	bidirectional_meter_disk_pulse_counter dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.edge_valid(edge_valid), .edge_stall(edge_stall),
		.sensor(sensor), .time_us(time_us), .time_ms(time_ms),
		.res_valid(res_valid), .res_stall(res_stall),
		.pulse_counted(pulse_counted), .double_pulse(double_pulse), .direction(direction),
		.power_w(power_w), .total_w(total_w), .used_w(used_w), .returned_w(returned_w)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		res_stall <= idle_on && ($urandom_range(0, 99) < 11);
	end

	function automatic logic [31:0] debounce_us();
		return 32'(set_debounce_ms) * 32'(US_PER_MS);
	endfunction

	function automatic logic [31:0] disk_power(logic [31:0] dur_ms);
		longint unsigned ppk;
		longint unsigned quot;
		ppk = 64'(set_ppk);
		if (dur_ms == 0 || ppk == 0)
			return POWER_MAX;
		// product would exceed the dividend: power rounds down to zero
		if (64'(dur_ms) > 64'(POWER_DIVIDEND) / ppk)
			return '0;
		quot = 64'(POWER_DIVIDEND) / (ppk * 64'(dur_ms));
		if (quot > 64'(POWER_MAX))
			quot = 64'(POWER_MAX);
		return 32'(quot);
	endfunction

	task automatic meter_update(bit s, logic [31:0] us, logic [31:0] ms);
		logic [31:0]    spacing;
		logic [31:0]    pw;
		rotation_t      mine;
		meter_reading_t r;
		mine = s ? ROT_RIGHT : ROT_LEFT;
		spacing = us - mark_us[s];
		r.pulse_counted = 1'b0;
		r.double_pulse = 1'b0;
		if (!spacing[31] && spacing >= debounce_us()) begin
			if (disk_rot == mine) begin
				// unsigned compare on purpose, no wrap handling
				if (mark_us[!s] > pulse_mark_us) begin
					pulse_mark_us = mark_us[s];
					r.pulse_counted = 1'b1;
				end else begin
					r.double_pulse = 1'b1;
				end
			end else if (pulse_mark_us == mark_us[!s]) begin
				disk_rot = mine;
			end
			mark_us[s] = us;
		end else begin
			debounced_seen++;
		end
		if (r.pulse_counted) begin
			pw = disk_power(ms - last_count_ms);
			last_count_ms = ms;
			pulses_seen++;
			if (disk_rot == ROT_LEFT) begin
				sum_returned += pw;
				watts_now = -pw;
				returning_seen++;
			end else begin
				sum_used += pw;
				watts_now = pw;
			end
			sum_net += watts_now;
		end
		if (r.double_pulse)
			doubles_seen++;
		r.direction = disk_rot;
		r.power_w = watts_now;
		r.total_w = sum_net;
		r.used_w = sum_used;
		r.returned_w = sum_returned;
		pending_readings.push_back(r);
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected 0x%08h actual 0x%08h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : take_reading
		meter_reading_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_readings.size() == 0) begin
				mismatches++;
				$display("%0t: reading with none expected, actual power 0x%08h total 0x%08h",
					$time, power_w, total_w);
			end else begin
				want = pending_readings.pop_front();
				readings_checked++;
				compare_field("pulse_counted", 32'(want.pulse_counted), 32'(pulse_counted));
				compare_field("double_pulse", 32'(want.double_pulse), 32'(double_pulse));
				compare_field("direction", 32'(want.direction), 32'(direction));
				compare_field("power_w", want.power_w, power_w);
				compare_field("total_w", want.total_w, total_w);
				compare_field("used_w", want.used_w, used_w);
				compare_field("returned_w", want.returned_w, returned_w);
			end
		end
	end

	task automatic send_edge(bit s, logic [31:0] us, logic [31:0] ms);
		while (idle_on && $urandom_range(0, 99) < 11) begin
			edge_valid <= 1'b0;
			@(posedge clk);
		end
		edge_valid <= 1'b1;
		sensor <= s;
		time_us <= us;
		time_ms <= ms;
		do
			@(posedge clk);
		while (edge_stall);
		meter_update(s, us, ms);
		items_sent++;
	endtask

	// edge far enough past the sensor's own last mark to pass debounce
	task automatic send_paced(bit s, logic [31:0] ms_step);
		logic [31:0]        stamp;
		logic signed [31:0] spacing;
		stamp = now_us + $urandom_range(0, 150000);
		spacing = stamp - mark_us[s];
		if (spacing < $signed(debounce_us()))
			stamp = mark_us[s] + debounce_us() + $urandom_range(0, 150000);
		now_us = stamp;
		now_ms += ms_step;
		last_sensor = s;
		send_edge(s, stamp, now_ms);
	endtask

	// Direction only flips when the pulse mark equals the other sensor's mark, so walk the
	// other sensor's mark onto the pulse mark (steps of 2^30 us), then fire sensor s.
	task automatic steer_rotation(bit s);
		rotation_t   want;
		logic [31:0] gap;
		int          n;
		want = s ? ROT_RIGHT : ROT_LEFT;
		for (n = 0; n < 8 && disk_rot != want; n++) begin
			gap = pulse_mark_us - mark_us[!s];
			now_ms += $urandom_range(1, 3000);
			if (gap == 0) begin
				now_us = mark_us[s] + debounce_us() + 32'd1000;
				send_edge(s, now_us, now_ms);
			end else if (!gap[31] && gap >= debounce_us()) begin
				now_us = pulse_mark_us;
				send_edge(!s, now_us, now_ms);
			end else begin
				now_us = mark_us[!s] + 32'h4000_0000;
				send_edge(!s, now_us, now_ms);
			end
		end
		last_sensor = s;
	endtask

	function automatic logic [31:0] pick_ms_step();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return $urandom_range(1, 3000);
		else if (pick < 80)
			return '0;
		else if (pick < 90)
			return $urandom_range(3000, 200000);
		return $urandom;
	endfunction

	task automatic random_edge();
		int          pick;
		bit          s;
		logic [31:0] thr;
		pick = $urandom_range(0, 99);
		thr = debounce_us();
		s = 1'($urandom);
		if (pick < 70) begin
			send_paced(($urandom_range(0, 9) == 0) ? last_sensor : !last_sensor, pick_ms_step());
		end else if (pick < 80 && thr != 0) begin
			// bounce inside the debounce window
			send_edge(s, mark_us[s] + $urandom_range(0, thr - 1), now_ms);
		end else if (pick < 92) begin
			send_edge(s, $urandom, $urandom);
		end else if (pick < 96) begin
			send_paced(last_sensor, pick_ms_step());
		end else begin
			steer_rotation(s);
		end
	endtask

	task automatic settle_readings();
		edge_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
	endtask

	task automatic program_meter(logic [15:0] deb, logic [15:0] ppk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_DEBOUNCE;
		cfg_data <= deb;
		do
			@(posedge clk);
		while (!cfg_ready);
		set_debounce_ms = deb;
		cfg_index <= REG_PPK;
		cfg_data <= ppk;
		do
			@(posedge clk);
		while (!cfg_ready);
		set_ppk = ppk;
		cfg_valid <= 1'b0;
		settings_seen++;
	endtask

	// reset settings: learning, counting, bounce, double, wrap, zero and long elapsed time
	task automatic test_directed_defaults();
		int k;
		send_edge(1'b0, 32'd0, 32'd0);
		send_edge(1'b1, 32'd100000, 32'd100);
		send_edge(1'b0, 32'd200000, 32'd200);
		send_edge(1'b1, 32'd300000, 32'd300);
		send_edge(1'b1, 32'd310000, 32'd310);
		send_edge(1'b0, 32'd400000, 32'd400);
		send_edge(1'b1, 32'd500000, 32'd500);
		send_edge(1'b1, 32'd600000, 32'd600);
		send_edge(1'b1, 32'd700000, 32'd700);
		// negative spacing once wrapped: rejected
		send_edge(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_edge(1'b1, 32'h7FFF_FFFF, 32'd800);
		send_edge(1'b0, 32'h8000_0000, 32'd900);
		send_edge(1'b1, 32'h8010_0000, 32'd600);
		send_edge(1'b0, 32'h8020_0000, 32'd700);
		send_edge(1'b1, 32'h8030_0000, 32'd10_000_600);
		now_us = 32'h8030_0000;
		now_ms = 32'd10_000_600;
		steer_rotation(1'b0);
		for (k = 0; k < 6; k++)
			send_paced(k[0], 32'd1000);
	endtask

	// zero debounce, one pulse per kWh: power saturates, equal stamps pass debounce
	task automatic test_directed_saturation();
		int k;
		settle_readings();
		program_meter(16'd0, 16'd1);
		for (k = 0; k < 4; k++)
			send_paced(k[0], 32'd1);
		send_edge(1'b0, mark_us[0], now_ms);
		steer_rotation(1'b1);
		for (k = 0; k < 4; k++)
			send_paced(!k[0], 32'd2);
	endtask

	task automatic test_random_sessions();
		logic [15:0] deb [6];
		logic [15:0] ppk [6];
		int          target;
		int          k;
		deb = '{16'd50, 16'd0, 16'hFFFF, 16'($urandom), 16'd1, 16'($urandom_range(0, 200))};
		ppk = '{16'd375, 16'd1, 16'hFFFF, 16'($urandom_range(1, 65535)), 16'd2,
			16'($urandom_range(1, 1000))};
		for (k = 0; k < 6; k++) begin
			settle_readings();
			program_meter(deb[k], ppk[k]);
			// one session runs with no idling on either side
			idle_on = (k != 2);
			target = items_sent + 205;
			while (items_sent < target)
				random_edge();
		end
		idle_on = 1'b1;
	endtask

	task automatic test_drain_pause();
		int k;
		for (k = 0; k < 30; k++)
			random_edge();
		settle_readings();
		for (k = 0; k < 30; k++)
			random_edge();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_DEBOUNCE;
		cfg_data = '0;
		edge_valid = 1'b0;
		sensor = 1'b0;
		time_us = '0;
		time_ms = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_directed_saturation();
		test_random_sessions();
		test_drain_pause();

		settle_readings();
		repeat (40) @(posedge clk);
		$display("%0d edges under %0d register settings: %0d debounced, %0d pulses",
			items_sent, settings_seen, debounced_seen, pulses_seen);
		$display("%0d returning pulses, %0d double pulses, %0d readings checked",
			returning_seen, doubles_seen, readings_checked);
		if (mismatches == 0) begin
			$display("tb_bidirectional_meter_disk_pulse_counter: done, clean");
		end else begin
			$display("tb_bidirectional_meter_disk_pulse_counter: done, errors");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_bidirectional_meter_disk_pulse_counter: done, errors");
		$finish;
	end

endmodule
